// ----- design/rmsd_pkg.sv -----
package rmsd_pkg;

  localparam int MAX_POSES  = 16;
  localparam int MAX_ATOMS  = 256;
  localparam int COORD_BITS = 16;

  localparam int POSE_W   = $clog2(MAX_POSES);
  localparam int CNT_W    = $clog2(MAX_POSES + 1);
  localparam int ATOM_W   = $clog2(MAX_ATOMS);
  localparam int NATOM_W  = $clog2(MAX_ATOMS + 1);
  localparam int SQ_W     = 2 * COORD_BITS + 1;
  localparam int SUM_W    = 44;
  localparam int THR_W    = 24 + NATOM_W;
  localparam int STORE_AW = POSE_W + ATOM_W;
  localparam int STORE_D  = MAX_POSES * MAX_ATOMS;
  localparam int ATOM_DW  = 3 * COORD_BITS;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_ATOM_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RMSD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POSE_LIMIT = 2'd2;

  localparam logic [2:0] ACT_SIM_REPL = 3'd0;
  localparam logic [2:0] ACT_SIM_KEPT = 3'd1;
  localparam logic [2:0] ACT_APPEND   = 3'd2;
  localparam logic [2:0] ACT_WORST    = 3'd3;
  localparam logic [2:0] ACT_DISCARD  = 3'd4;

  localparam logic REQ_ATOM = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic KIND_DEC  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic                         req_type;
    logic signed [COORD_BITS-1:0] x_coord;
    logic signed [COORD_BITS-1:0] y_coord;
    logic signed [COORD_BITS-1:0] z_coord;
    logic signed [31:0]           pose_energy;
    logic [3:0]                   read_rank;
    logic [7:0]                   read_atom;
  } in_word_t;

  typedef struct packed {
    logic                         result_kind;
    logic [2:0]                   action;
    logic [3:0]                   new_rank;
    logic [4:0]                   pose_total;
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic signed [COORD_BITS-1:0] out_z;
    logic signed [31:0]           out_energy;
  } out_word_t;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_RD      = 10'b0000000010,
    S_ACC_RD  = 10'b0000000100,
    S_ACC_MUL = 10'b0000001000,
    S_ACC_ADD = 10'b0000010000,
    S_MIN     = 10'b0000100000,
    S_DEC     = 10'b0001000000,
    S_COPY    = 10'b0010000000,
    S_SORT    = 10'b0100000000,
    S_REORD   = 10'b1000000000
  } state_e;

endpackage

// ----- design/rmsd_ram.sv -----
module rmsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/rmsd_diverse_pose_keeper.sv -----
// Atom word: for each stored pose one store read, square and add (S_ACC_RD, S_ACC_MUL,
// S_ACC_ADD). The last atom adds the closest-pose search, a decision, and, when the pose
// is stored, a copy of its atoms and a ranking pass; then the result is emitted. Read
// word: one read through the pose memory, emitted from S_RD. One word in flight at a
// time. Reset: asynchronous, active low; clears the list, the distance sums and the
// control registers; pose memories, energies and datapath registers are not cleared.
module rmsd_diverse_pose_keeper
  import rmsd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_word_t             in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_word_t            out_word_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0]    cfg_data_i
);

  state_e state_q, state_d;

  logic [8:0]  atom_count_q;
  logic [23:0] min_rmsd_q;
  logic [4:0]  pose_limit_q;

  logic [POSE_W-1:0]  rank_q [MAX_POSES];
  logic signed [31:0] energy_mem_q [MAX_POSES];
  logic [SUM_W-1:0]   sum_q [MAX_POSES];
  logic [CNT_W-1:0]   count_q;
  logic [ATOM_W-1:0]  pos_q;

  logic [ATOM_DW-1:0] atom_q;
  logic signed [31:0] energy_q;
  logic [3:0]         rrank_q;
  logic [POSE_W-1:0]  r_q;
  logic [SQ_W-1:0]    sq_q [3];
  logic [POSE_W-1:0]  best_q;
  logic [SUM_W-1:0]   best_sum_q;
  logic               have_q;
  logic [THR_W-1:0]   thr_q;
  logic [2:0]         act_q;
  logic               store_q;
  logic [POSE_W-1:0]  tgt_q;
  logic [POSE_W-1:0]  p_q;
  logic [POSE_W-1:0]  k_q;
  logic [ATOM_W-1:0]  a_q;
  logic               cpy_done_q;
  logic               cpy_v_q;
  logic [ATOM_W-1:0]  cpy_a_q;

  out_word_t out_q;
  logic      out_valid_q;

  logic [NATOM_W-1:0] n_eff;
  logic [CNT_W-1:0]   limit_eff;
  logic               in_acc;
  logic               out_free;
  logic               last_atom;

  logic                st_re;
  logic [STORE_AW-1:0] st_raddr;
  logic [ATOM_DW-1:0]  st_rdata;
  logic                in_re;
  logic [ATOM_DW-1:0]  in_rdata;

  logic [POSE_W-1:0]  en_slot;
  logic signed [31:0] en_rd;

  logic               similar;
  logic [2:0]         dec_act;
  logic               dec_store;
  logic [POSE_W-1:0]  dec_p;
  logic [CNT_W-1:0]   dec_count;

  logic [POSE_W-1:0] others [MAX_POSES];
  logic [POSE_W-1:0] rank_new [MAX_POSES];

  logic signed [COORD_BITS:0]     dif [3];
  logic signed [2*COORD_BITS+1:0] prod [3];

  always_comb begin
    if (atom_count_q == 9'd0) begin
      n_eff = NATOM_W'(1);
    end else if (atom_count_q > 9'(MAX_ATOMS)) begin
      n_eff = NATOM_W'(MAX_ATOMS);
    end else begin
      n_eff = NATOM_W'(atom_count_q);
    end
    if (pose_limit_q == 5'd0) begin
      limit_eff = CNT_W'(1);
    end else if (pose_limit_q > 5'(MAX_POSES)) begin
      limit_eff = CNT_W'(MAX_POSES);
    end else begin
      limit_eff = CNT_W'(pose_limit_q);
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign last_atom  = (NATOM_W'(pos_q) + NATOM_W'(1)) >= n_eff;

  always_comb begin
    st_re    = 1'b0;
    st_raddr = {rank_q[r_q], pos_q};
    if (state_q == S_IDLE) begin
      st_re    = in_acc && (in_word_i.req_type == REQ_READ);
      st_raddr = {rank_q[in_word_i.read_rank[POSE_W-1:0]], in_word_i.read_atom[ATOM_W-1:0]};
    end else if (state_q == S_ACC_RD) begin
      st_re = 1'b1;
    end
  end

  assign in_re = (state_q == S_COPY) && !cpy_done_q;

  rmsd_ram #(.WIDTH(ATOM_DW), .DEPTH(STORE_D)) u_store (
    .clk_i   (clk_i),
    .we_i    (cpy_v_q),
    .waddr_i ({tgt_q, cpy_a_q}),
    .wdata_i (in_rdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  rmsd_ram #(.WIDTH(ATOM_DW), .DEPTH(MAX_ATOMS)) u_incoming (
    .clk_i   (clk_i),
    .we_i    (in_acc && (in_word_i.req_type == REQ_ATOM)),
    .waddr_i (pos_q),
    .wdata_i ({in_word_i.x_coord, in_word_i.y_coord, in_word_i.z_coord}),
    .re_i    (in_re),
    .raddr_i (a_q),
    .rdata_o (in_rdata)
  );

  always_comb begin
    case (state_q)
      S_DEC:   en_slot = similar ? rank_q[best_q] : rank_q[POSE_W'(count_q - CNT_W'(1))];
      S_SORT:  en_slot = rank_q[r_q];
      S_RD:    en_slot = rank_q[rrank_q[POSE_W-1:0]];
      default: en_slot = rank_q[0];
    endcase
  end
  assign en_rd = energy_mem_q[en_slot];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dif[i] = {atom_q[ATOM_DW-1-i*COORD_BITS], atom_q[ATOM_DW-1-i*COORD_BITS -: COORD_BITS]}
             - {st_rdata[ATOM_DW-1-i*COORD_BITS], st_rdata[ATOM_DW-1-i*COORD_BITS -: COORD_BITS]};
      prod[i] = dif[i] * dif[i];
    end
  end

  always_comb begin
    similar   = (count_q != '0) && (best_sum_q < SUM_W'(thr_q));
    dec_act   = ACT_DISCARD;
    dec_store = 1'b0;
    dec_p     = '0;
    dec_count = count_q;
    if (similar) begin
      if (energy_q < en_rd) begin
        dec_act   = ACT_SIM_REPL;
        dec_store = 1'b1;
        dec_p     = best_q;
      end else begin
        dec_act = ACT_SIM_KEPT;
      end
    end else if (count_q < limit_eff) begin
      dec_act   = ACT_APPEND;
      dec_store = 1'b1;
      dec_p     = POSE_W'(count_q);
      dec_count = count_q + CNT_W'(1);
    end else if ((count_q != '0) && (energy_q < en_rd)) begin
      dec_act   = ACT_WORST;
      dec_store = 1'b1;
      dec_p     = POSE_W'(count_q - CNT_W'(1));
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_POSES; i++) begin
      if (i < MAX_POSES - 1) begin
        others[i] = (POSE_W'(i) < p_q) ? rank_q[i] : rank_q[i+1];
      end else begin
        others[i] = rank_q[i];
      end
    end
    for (int i = 0; i < MAX_POSES; i++) begin
      if (POSE_W'(i) < k_q) begin
        rank_new[i] = others[i];
      end else if (POSE_W'(i) == k_q) begin
        rank_new[i] = tgt_q;
      end else begin
        rank_new[i] = others[(i > 0) ? i - 1 : 0];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_word_i.req_type == REQ_READ) begin
            state_d = S_RD;
          end else if (count_q != '0) begin
            state_d = S_ACC_RD;
          end else begin
            state_d = last_atom ? S_MIN : S_IDLE;
          end
        end
      end
      S_RD:      state_d = out_free ? S_IDLE : S_RD;
      S_ACC_RD:  state_d = S_ACC_MUL;
      S_ACC_MUL: state_d = S_ACC_ADD;
      S_ACC_ADD: begin
        if ((CNT_W'(r_q) + CNT_W'(1)) < count_q) begin
          state_d = S_ACC_RD;
        end else begin
          state_d = last_atom ? S_MIN : S_IDLE;
        end
      end
      S_MIN: begin
        if ((count_q == '0) || ((CNT_W'(r_q) + CNT_W'(1)) >= count_q)) begin
          state_d = S_DEC;
        end
      end
      S_DEC:  state_d = dec_store ? S_COPY : S_REORD;
      S_COPY: state_d = (cpy_done_q && !cpy_v_q) ? S_SORT : S_COPY;
      S_SORT: state_d = ((CNT_W'(r_q) + CNT_W'(1)) >= count_q) ? S_REORD : S_SORT;
      S_REORD: state_d = out_free ? S_IDLE : S_REORD;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      atom_count_q <= 9'd1;
      min_rmsd_q   <= 24'd65536;
      pose_limit_q <= 5'd16;
      count_q      <= '0;
      pos_q        <= '0;
      out_valid_q  <= 1'b0;
      cpy_v_q      <= 1'b0;
      cpy_done_q   <= 1'b0;
      for (int i = 0; i < MAX_POSES; i++) begin
        rank_q[i] <= POSE_W'(i);
        sum_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ATOM_COUNT: atom_count_q <= cfg_data_i[8:0];
          CFG_MIN_RMSD:   min_rmsd_q   <= cfg_data_i[23:0];
          CFG_POSE_LIMIT: pose_limit_q <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (((state_q == S_RD) || (state_q == S_REORD)) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      cpy_v_q <= in_re;
      case (state_q)
        S_IDLE: begin
          if (in_acc && (in_word_i.req_type == REQ_ATOM) && (count_q == '0) && !last_atom) begin
            pos_q <= pos_q + ATOM_W'(1);
          end
        end
        S_ACC_ADD: begin
          sum_q[r_q] <= sum_q[r_q] + SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
          if (((CNT_W'(r_q) + CNT_W'(1)) >= count_q) && !last_atom) begin
            pos_q <= pos_q + ATOM_W'(1);
          end
        end
        S_DEC: begin
          count_q    <= dec_count;
          cpy_done_q <= 1'b0;
        end
        S_COPY: begin
          if (in_re && ((NATOM_W'(a_q) + NATOM_W'(1)) >= n_eff)) begin
            cpy_done_q <= 1'b1;
          end
        end
        S_REORD: begin
          if (out_free) begin
            pos_q <= '0;
            for (int i = 0; i < MAX_POSES; i++) begin
              sum_q[i] <= '0;
              if (store_q) begin
                rank_q[i] <= rank_new[i];
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        atom_q   <= {in_word_i.x_coord, in_word_i.y_coord, in_word_i.z_coord};
        energy_q <= in_word_i.pose_energy;
        rrank_q  <= in_word_i.read_rank;
        r_q      <= '0;
        have_q   <= 1'b0;
      end
      S_RD: begin
        if (out_free) begin
          out_q.result_kind <= KIND_READ;
          out_q.action      <= ACT_SIM_REPL;
          out_q.new_rank    <= '0;
          out_q.pose_total  <= 5'(count_q);
          if (CNT_W'(rrank_q) < count_q) begin
            out_q.out_x      <= st_rdata[ATOM_DW-1 -: COORD_BITS];
            out_q.out_y      <= st_rdata[ATOM_DW-1-COORD_BITS -: COORD_BITS];
            out_q.out_z      <= st_rdata[COORD_BITS-1:0];
            out_q.out_energy <= en_rd;
          end else begin
            out_q.out_x      <= '0;
            out_q.out_y      <= '0;
            out_q.out_z      <= '0;
            out_q.out_energy <= '0;
          end
        end
      end
      S_ACC_MUL: begin
        for (int i = 0; i < 3; i++) begin
          sq_q[i] <= prod[i][SQ_W-1:0];
        end
      end
      S_ACC_ADD: begin
        r_q <= ((CNT_W'(r_q) + CNT_W'(1)) < count_q) ? r_q + POSE_W'(1) : '0;
      end
      S_MIN: begin
        thr_q <= THR_W'(min_rmsd_q) * THR_W'(n_eff);
        if (count_q != '0) begin
          if (!have_q || (sum_q[r_q] < best_sum_q)) begin
            best_q     <= r_q;
            best_sum_q <= sum_q[r_q];
          end
          have_q <= 1'b1;
          r_q    <= r_q + POSE_W'(1);
        end
      end
      S_DEC: begin
        act_q   <= dec_act;
        store_q <= dec_store;
        p_q     <= dec_p;
        tgt_q   <= rank_q[dec_p];
        k_q     <= '0;
        r_q     <= '0;
        a_q     <= '0;
        if (dec_store) begin
          energy_mem_q[rank_q[dec_p]] <= energy_q;
        end
      end
      S_COPY: begin
        if (in_re) begin
          a_q <= a_q + ATOM_W'(1);
        end
        cpy_a_q <= a_q;
      end
      S_SORT: begin
        if ((r_q != p_q) && ((en_rd < energy_q) || ((en_rd == energy_q) && (r_q < p_q)))) begin
          k_q <= k_q + POSE_W'(1);
        end
        r_q <= r_q + POSE_W'(1);
      end
      S_REORD: begin
        if (out_free) begin
          out_q.result_kind <= KIND_DEC;
          out_q.action      <= act_q;
          out_q.new_rank    <= store_q ? 4'(k_q) : 4'd0;
          out_q.pose_total  <= 5'(count_q);
          out_q.out_x       <= '0;
          out_q.out_y       <= '0;
          out_q.out_z       <= '0;
          out_q.out_energy  <= '0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_POSES))
    else $error("pose count beyond capacity");

  a_copy_stores: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COPY) |-> store_q)
    else $error("copy without a stored pose");

  a_dec_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_q) && (out_q.result_kind == KIND_DEC)) |-> (pos_q == '0))
    else $error("atom position not cleared after decision");

  a_read_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.result_kind == KIND_READ)) |-> (out_q.action == ACT_SIM_REPL))
    else $error("read word carries an action");
`endif

endmodule

// ----- sim/rmsd_diverse_pose_keeper_tb.sv -----
`timescale 1ns / 1ps

module rmsd_diverse_pose_keeper_tb;
  import rmsd_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 80;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  in_word_t             in_word_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  out_word_t            out_word_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DW-1:0]    cfg_data_i;

  rmsd_diverse_pose_keeper i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // pose list mirror
  logic signed [15:0] pose_x [MAX_POSES][MAX_ATOMS];
  logic signed [15:0] pose_y [MAX_POSES][MAX_ATOMS];
  logic signed [15:0] pose_z [MAX_POSES][MAX_ATOMS];
  logic signed [31:0] pose_e [MAX_POSES];
  int                 atoms_written [MAX_POSES];
  int                 rank_of [MAX_POSES];
  int                 stored_n;
  longint unsigned    dist_sum [MAX_POSES];
  logic signed [15:0] new_x [MAX_ATOMS];
  logic signed [15:0] new_y [MAX_ATOMS];
  logic signed [15:0] new_z [MAX_ATOMS];
  int                 atom_pos;
  int                 last_target;
  int                 cfg_atoms, cfg_rmsd, cfg_limit;

  out_word_t pending_results[$];
  int        errors, items_sent, n_reads, n_holds, cycles;
  int        action_hits [5];
  bit        idling_on, hold_long;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("rmsd_diverse_pose_keeper_tb: errors");
      $finish;
    end
  end

  function automatic int eff_atoms();
    if (cfg_atoms == 0) return 1;
    if (cfg_atoms > MAX_ATOMS) return MAX_ATOMS;
    return cfg_atoms;
  endfunction

  function automatic int eff_limit();
    if (cfg_limit == 0) return 1;
    if (cfg_limit > MAX_POSES) return MAX_POSES;
    return cfg_limit;
  endfunction

  task automatic predict_keeper_word(in_word_t w);
    out_word_t          o;
    int                 n, pos, s, best, tgt, lim, i, j;
    bit                 have;
    logic [2:0]         act;
    longint unsigned    thr;
    longint             dx, dy, dz;
    logic signed [31:0] e;
    o = '0;
    if (w.req_type == REQ_READ) begin
      o.result_kind = KIND_READ;
      o.pose_total  = 5'(stored_n);
      if (w.read_rank < stored_n) begin
        s = rank_of[w.read_rank];
        o.out_x      = pose_x[s][w.read_atom];
        o.out_y      = pose_y[s][w.read_atom];
        o.out_z      = pose_z[s][w.read_atom];
        o.out_energy = pose_e[s];
      end
      pending_results = {pending_results, o};
      n_reads++;
      return;
    end
    n   = eff_atoms();
    pos = atom_pos;
    new_x[pos] = w.x_coord;
    new_y[pos] = w.y_coord;
    new_z[pos] = w.z_coord;
    for (i = 0; i < stored_n; i++) begin
      s  = rank_of[i];
      dx = longint'(w.x_coord) - longint'(pose_x[s][pos]);
      dy = longint'(w.y_coord) - longint'(pose_y[s][pos]);
      dz = longint'(w.z_coord) - longint'(pose_z[s][pos]);
      dist_sum[i] += longint'(dx * dx + dy * dy + dz * dz);
    end
    if (pos + 1 < n) begin
      atom_pos = pos + 1;
      return;
    end
    e    = w.pose_energy;
    thr  = longint'(cfg_rmsd) * n;
    lim  = eff_limit();
    tgt  = -1;
    have = 1'b0;
    best = 0;
    for (i = 0; i < stored_n; i++)
      if (!have || dist_sum[i] < dist_sum[best]) begin
        best = i;
        have = 1'b1;
      end
    if (have && dist_sum[best] < thr) begin
      if (e < pose_e[rank_of[best]]) begin
        tgt = rank_of[best];
        act = ACT_SIM_REPL;
      end else begin
        act = ACT_SIM_KEPT;
      end
    end else if (stored_n < lim) begin
      tgt = rank_of[stored_n];
      stored_n++;
      act = ACT_APPEND;
    end else if (stored_n > 0 && e < pose_e[rank_of[stored_n-1]]) begin
      tgt = rank_of[stored_n-1];
      act = ACT_WORST;
    end else begin
      act = ACT_DISCARD;
    end
    if (tgt >= 0) begin
      for (i = 0; i < n; i++) begin
        pose_x[tgt][i] = new_x[i];
        pose_y[tgt][i] = new_y[i];
        pose_z[tgt][i] = new_z[i];
      end
      pose_e[tgt] = e;
      if (atoms_written[tgt] < n) atoms_written[tgt] = n;
      last_target = tgt;
    end
    for (i = 1; i < stored_n; i++) begin
      s = rank_of[i];
      j = i;
      while (j > 0 && pose_e[rank_of[j-1]] > pose_e[s]) begin
        rank_of[j] = rank_of[j-1];
        j--;
      end
      rank_of[j] = s;
    end
    o.result_kind = KIND_DEC;
    o.action      = act;
    if (tgt >= 0)
      for (j = 0; j < stored_n; j++)
        if (rank_of[j] == tgt) o.new_rank = 4'(j);
    o.pose_total = 5'(stored_n);
    pending_results = {pending_results, o};
    action_hits[act]++;
    for (i = 0; i < MAX_POSES; i++) dist_sum[i] = 0;
    atom_pos = 0;
  endtask

  task automatic send_word(in_word_t w);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    predict_keeper_word(w);
    items_sent++;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk_i);
    end
  endtask

  task automatic send_atom(logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] z, logic signed [31:0] e);
    in_word_t    w;
    logic [95:0] rnd;
    rnd = {$urandom, $urandom, $urandom};
    w   = rnd[$bits(in_word_t)-1:0];
    w.req_type    = REQ_ATOM;
    w.x_coord     = x;
    w.y_coord     = y;
    w.z_coord     = z;
    w.pose_energy = e;
    send_word(w);
  endtask

  task automatic send_read(int rank, int atom);
    in_word_t    w;
    logic [95:0] rnd;
    rnd = {$urandom, $urandom, $urandom};
    w   = rnd[$bits(in_word_t)-1:0];
    w.req_type  = REQ_READ;
    w.read_rank = 4'(rank);
    w.read_atom = 8'(atom);
    send_word(w);
  endtask

  task automatic send_rand_read();
    int rank, s;
    if (stored_n > 0 && (stored_n == MAX_POSES || $urandom_range(0, 5) != 0)) begin
      rank = $urandom_range(0, stored_n - 1);
      s    = rank_of[rank];
      send_read(rank, $urandom_range(0, atoms_written[s] - 1));
    end else begin
      send_read($urandom_range(stored_n, MAX_POSES - 1), $urandom_range(0, 255));
    end
  endtask

  function automatic logic signed [31:0] rand_energy();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 8)) - 4;
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  // base >= 0: perturb that slot by up to +/-scale; -1: random; -2: corner values
  task automatic send_pose(int base, int scale, logic signed [31:0] e, int read_pct);
    int                 n, i;
    logic signed [15:0] x, y, z;
    n = eff_atoms();
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < read_pct) send_rand_read();
      if (base >= 0) begin
        x = pose_x[base][i] + 16'($signed($urandom_range(0, 2 * scale)) - scale);
        y = pose_y[base][i] + 16'($signed($urandom_range(0, 2 * scale)) - scale);
        z = pose_z[base][i] + 16'($signed($urandom_range(0, 2 * scale)) - scale);
      end else if (base == -2) begin
        x = i[0] ? 16'sh8000 : 16'sh7fff;
        y = i[0] ? 16'sh7fff : 16'sh8000;
        z = i[0] ? 16'sh0000 : 16'sh7fff;
      end else begin
        x = 16'($urandom);
        y = 16'($urandom);
        z = 16'($urandom);
      end
      send_atom(x, y, z, (i == n - 1) ? e : rand_energy());
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int value);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DW'(value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_ATOM_COUNT: cfg_atoms = value & 'h1ff;
      CFG_MIN_RMSD:   cfg_rmsd  = value & 'hffffff;
      CFG_POSE_LIMIT: cfg_limit = value & 'h1f;
      default: ;
    endcase
  endtask

  task automatic run_random(int n_items, int read_pct);
    int stop, base, scale;
    stop = items_sent + n_items;
    while (items_sent < stop) begin
      base = -1;
      if (stored_n > 0 && $urandom_range(0, 9) < 6)
        base = rank_of[$urandom_range(0, stored_n - 1)];
      scale = $urandom_range(0, 1) ? 32 : $urandom_range(0, 400);
      send_pose(base, scale, rand_energy(), read_pct);
    end
  endtask

  // a full-size pose first, so one slot holds the most atoms later phases touch
  task automatic test_full_size_pose();
    cfg_write(CFG_POSE_LIMIT, 1);
    cfg_write(CFG_ATOM_COUNT, 511);
    send_pose(-1, 0, 1000, 0);
    send_read(0, 255);
  endtask

  task automatic test_directed_actions();
    int p1;
    cfg_write(CFG_ATOM_COUNT, 4);
    cfg_write(CFG_POSE_LIMIT, 3);
    cfg_write(CFG_MIN_RMSD, 65536);
    send_read(15, 0);
    send_pose(-2, 0, 100, 0);
    p1 = last_target;
    send_pose(p1, 0, 50, 0);
    send_pose(p1, 0, 50, 0);
    send_pose(-1, 0, 32'sh7fffffff, 0);
    send_pose(-1, 0, 32'sh7fffffff, 0);
    send_pose(-1, 0, -5, 0);
    send_read(2, 3);
  endtask

  task automatic test_random_max_threshold();
    cfg_write(CFG_POSE_LIMIT, 31);
    cfg_write(CFG_MIN_RMSD, 24'hffffff);
    run_random(110, 20);
  endtask

  task automatic test_count_lowered_mid_pose();
    send_atom(16'($urandom), 16'($urandom), 16'($urandom), rand_energy());
    send_atom(16'($urandom), 16'($urandom), 16'($urandom), rand_energy());
    cfg_write(CFG_ATOM_COUNT, 3);
    send_atom(16'($urandom), 16'($urandom), 16'($urandom), rand_energy());
  endtask

  task automatic test_random_zero_threshold();
    cfg_write(CFG_POSE_LIMIT, 16);
    cfg_write(CFG_MIN_RMSD, 0);
    run_random(90, 15);
  endtask

  task automatic test_backpressure_short_list();
    cfg_write(CFG_ATOM_COUNT, 2);
    cfg_write(CFG_POSE_LIMIT, 5);
    cfg_write(CFG_MIN_RMSD, 65536);
    hold_long = 1'b1;
    run_random(84, 25);
  endtask

  task automatic test_single_atom_no_idle();
    cfg_write(CFG_ATOM_COUNT, 0);
    cfg_write(CFG_POSE_LIMIT, 0);
    cfg_write(CFG_MIN_RMSD, 300000);
    idling_on = 1'b0;
    run_random(80, 30);
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none, actual %h", $time, out_word_o);
      end else begin
        exp_w = pending_results.pop_front();
        check_field("result_kind", exp_w.result_kind, out_word_o.result_kind);
        check_field("action", exp_w.action, out_word_o.action);
        check_field("new_rank", exp_w.new_rank, out_word_o.new_rank);
        check_field("pose_total", exp_w.pose_total, out_word_o.pose_total);
        check_field("out_x", exp_w.out_x, out_word_o.out_x);
        check_field("out_y", exp_w.out_y, out_word_o.out_y);
        check_field("out_z", exp_w.out_z, out_word_o.out_z);
        check_field("out_energy", exp_w.out_energy, out_word_o.out_energy);
      end
    end
  end

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_long = 1'b0;
        n_holds++;
        out_stall_i <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_word_i  = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    cfg_atoms  = 1;
    cfg_rmsd   = 65536;
    cfg_limit  = 16;
    stored_n   = 0;
    atom_pos   = 0;
    idling_on  = 1'b1;
    hold_long  = 1'b0;
    for (int i = 0; i < MAX_POSES; i++) begin
      rank_of[i]       = i;
      dist_sum[i]      = 0;
      atoms_written[i] = 0;
    end
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    test_full_size_pose();
    test_directed_actions();
    test_random_max_threshold();
    test_count_lowered_mid_pose();
    test_random_zero_threshold();
    test_backpressure_short_list();
    test_single_atom_no_idle();
    wait_idle();

    $display("covered %0d words: %0d reads, %0d long output holds", items_sent, n_reads,
             n_holds);
    $display("decisions: replaced %0d, kept %0d, appended %0d, worst %0d, discarded %0d",
             action_hits[0], action_hits[1], action_hits[2], action_hits[3],
             action_hits[4]);
    if (errors == 0) begin
      $display("rmsd_diverse_pose_keeper_tb: clean");
    end else begin
      $display("rmsd_diverse_pose_keeper_tb: errors");
    end
    $finish;
  end

endmodule
